/* rtl/core/cda_pkg.sv */
// Shared types, constants and a calendar function for the date advance unit.
`timescale 1ns / 1ps

package cda_pkg;

    localparam logic [3:0]  MONTH_JAN    = 4'd1;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [3:0]  MONTH_DEC    = 4'd12;
    localparam logic [4:0]  DAY_FIRST    = 5'd1;
    localparam logic [13:0] LEAP_PERIOD  = 14'd400;
    localparam logic [13:0] YEAR_MAX     = 14'h3FFF;
    localparam int          REDUCE_STEPS = 6;

    typedef struct packed {
        logic [4:0]  start_day;
        logic [3:0]  start_month;
        logic [13:0] start_year;
        logic [15:0] days_ahead;
    } t_date_in;

    typedef struct packed {
        logic [4:0]  end_day;
        logic [3:0]  end_month;
        logic [13:0] end_year;
        logic        date_valid;
    } t_date_out;

    function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        len = 5'd0;
        case (month) inside
            MONTH_FEB:                                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:                        len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, MONTH_DEC: len = 5'd31;
            default:                                        len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

/* rtl/core/calendar_date_advance_unit.sv */
// Top level: Gregorian date check and day-by-day advance over a shared step unit.
`timescale 1ns / 1ps
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one request beat (start date
//   and day count). A beat is taken when i_in_valid is high and o_in_stall low.
//   Output channel: o_out_valid / i_out_stall carry one result beat per request
//   (end date and date_valid flag; invalid dates return zero fields).
//   Sequence: REDUCE_STEPS steps of year-modulo-400 reduction through one
//   compare and subtract unit, a check state, then one step per day of the
//   count (low COUNT_BITS bits of days_ahead), then a load of the result
//   register.
//   Requests: the day stepper is the bottleneck; a new request is taken
//   only when the sequencer is idle, while the previous result may still
//   sit in the output register.
//   Receiver stall: the result beat holds in the output register; a finished
//   request waits in its final state until that register frees up.
//   Reset (synchronous, active low): the sequencer returns to idle and the
//   output register is emptied.
module calendar_date_advance_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cda_pkg::t_date_in   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cda_pkg::t_date_out  o_out_data
);
    import cda_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_STEP,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [4:0]            r_day;
    logic [3:0]            r_month;
    logic [13:0]           r_year;
    logic [13:0]           r_rem;
    logic [2:0]            r_k;
    logic [COUNT_BITS-1:0] r_left;
    logic                  r_ok;
    t_date_out             r_out;
    logic                  r_out_valid;

    logic [14:0]           n_diff;
    logic [13:0]           n_sub;
    logic                  n_leap;
    logic [4:0]            n_len;
    logic [4:0]            n_day;
    logic [3:0]            n_month;
    logic [13:0]           n_year;
    logic [13:0]           n_rem;
    logic                  n_take;
    logic                  n_out_free;

    assign n_take     = i_in_valid && (r_state == S_IDLE);
    assign n_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_sub  = 14'(LEAP_PERIOD << r_k);
        n_diff = {1'b0, r_rem} - {1'b0, n_sub};
        n_leap = (r_year[1:0] == 2'b00) && !(r_rem inside {14'd100, 14'd200, 14'd300});
        n_len  = month_length(r_month, n_leap);
    end

    // Advance one day, tracking year modulo 400 alongside the year.
    always_comb begin
        n_day   = r_day + 5'd1;
        n_month = r_month;
        n_year  = r_year;
        n_rem   = r_rem;
        if (r_day >= n_len) begin
            n_day = DAY_FIRST;
            if (r_month >= MONTH_DEC) begin
                n_month = MONTH_JAN;
                n_year  = 14'(r_year + 14'd1);
                if (r_year == YEAR_MAX) begin
                    n_rem = '0;
                end else if (r_rem == LEAP_PERIOD - 14'd1) begin
                    n_rem = '0;
                end else begin
                    n_rem = 14'(r_rem + 14'd1);
                end
            end else begin
                n_month = 4'(r_month + 4'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_ok        <= 1'b0;
            r_day       <= '0;
            r_month     <= '0;
            r_year      <= '0;
            r_rem       <= '0;
            r_left      <= '0;
            r_out       <= '0;
        end else begin
            if ((r_state == S_DONE) && n_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_take) begin
                        r_day   <= i_in_data.start_day;
                        r_month <= i_in_data.start_month;
                        r_year  <= i_in_data.start_year;
                        r_rem   <= i_in_data.start_year;
                        r_left  <= COUNT_BITS'(i_in_data.days_ahead);
                        r_k     <= 3'(REDUCE_STEPS - 1);
                        r_state <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    if (!n_diff[14]) begin
                        r_rem <= n_diff[13:0];
                    end
                    if (r_k == '0) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_k <= r_k - 3'd1;
                    end
                end
                S_CHECK: begin
                    r_ok <= (n_len != 5'd0) && (r_day >= DAY_FIRST) && (r_day <= n_len);
                    if ((n_len == 5'd0) || (r_day < DAY_FIRST) || (r_day > n_len)) begin
                        r_day   <= '0;
                        r_month <= '0;
                        r_year  <= '0;
                        r_left  <= '0;
                        r_state <= S_DONE;
                    end else if (r_left == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    r_day   <= n_day;
                    r_month <= n_month;
                    r_year  <= n_year;
                    r_rem   <= n_rem;
                    r_left  <= r_left - COUNT_BITS'(1);
                    if (r_left == COUNT_BITS'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_out.end_day    <= r_day;
                        r_out.end_month  <= r_month;
                        r_out.end_year   <= r_year;
                        r_out.date_valid <= r_ok;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/core/cda_checker.sv */
// Port-level checker for the date advance unit, bound to the top level.
`timescale 1ns / 1ps

module cda_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  cda_pkg::t_date_out  o_out_data
);
    import cda_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.date_valid) |->
        (o_out_data.end_day == 5'd0 && o_out_data.end_month == 4'd0 &&
         o_out_data.end_year == 14'd0))
        else $error("invalid date with nonzero fields");

    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.date_valid) |->
        (o_out_data.end_month >= MONTH_JAN && o_out_data.end_month <= MONTH_DEC &&
         o_out_data.end_day >= DAY_FIRST && o_out_data.end_day <= 5'd31))
        else $error("valid result date out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present after reset");

endmodule

bind calendar_date_advance_unit cda_checker u_cda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

/* bench/tb_calendar_date_advance_unit.sv */
// Self-checking bench for the calendar date advance unit: directed and random dates.
`timescale 1ns / 1ps

module tb_calendar_date_advance_unit;

    import cda_pkg::*;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int RANDOM_ITEMS = 70;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_date_in  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_date_out o_out_data;

    t_date_out end_date_q[$];
    t_date_out want_date;
    int        mismatch_count = 0;
    int        dates_checked  = 0;
    int        dates_sent     = 0;
    int        cycle_count    = 0;
    int        hold_ticket    = 0;
    int        hold_served    = 0;
    int        hold_left      = 0;
    logic      calm           = 1'b0;

    calendar_date_advance_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int days_in_month(input logic [3:0] month, input logic [13:0] year);
        int  y;
        bit  leap;
        y = int'(year);
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (month)
            4'd2:                                  return leap ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11:               return 30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
            4'd12:                                 return 31;
            default:                               return 0;
        endcase
    endfunction

    function automatic t_date_out advance_date(input t_date_in req);
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        int          len;
        t_date_out   res;
        res   = '0;
        day   = req.start_day;
        month = req.start_month;
        year  = req.start_year;
        len   = days_in_month(month, year);
        if (len == 0 || day == 0 || day > len) begin
            return res;
        end
        for (int n = 0; n < int'(req.days_ahead); n++) begin
            if (day >= days_in_month(month, year)) begin
                day = DAY_FIRST;
                if (month >= MONTH_DEC) begin
                    month = MONTH_JAN;
                    year  = year + 14'd1;
                end else begin
                    month = month + 4'd1;
                end
            end else begin
                day = day + 5'd1;
            end
        end
        res.end_day    = day;
        res.end_month  = month;
        res.end_year   = year;
        res.date_valid = 1'b1;
        return res;
    endfunction

    function automatic t_date_in date_req(input int day, input int month, input int year,
                                          input int count);
        t_date_in req;
        req.start_day   = day[4:0];
        req.start_month = month[3:0];
        req.start_year  = year[13:0];
        req.days_ahead  = count[15:0];
        return req;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want,
                 cycle_count);
    endtask

    task automatic send_date(input t_date_in req);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        end_date_q.push_back(advance_date(req));
        dates_sent++;
        if (!calm && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    // receiver stall: long hold-off on request, otherwise random or calm
    always @(posedge i_clk) begin
        if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 12);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (end_date_q.size() == 0) begin
                report_mismatch("result beat with no request waiting", 32'(o_out_data), 0);
            end else begin
                want_date = end_date_q.pop_front();
                dates_checked++;
                if (o_out_data.end_day !== want_date.end_day)
                    report_mismatch("end_day", 32'(o_out_data.end_day),
                                    32'(want_date.end_day));
                if (o_out_data.end_month !== want_date.end_month)
                    report_mismatch("end_month", 32'(o_out_data.end_month),
                                    32'(want_date.end_month));
                if (o_out_data.end_year !== want_date.end_year)
                    report_mismatch("end_year", 32'(o_out_data.end_year),
                                    32'(want_date.end_year));
                if (o_out_data.date_valid !== want_date.date_valid)
                    report_mismatch("date_valid", 32'(o_out_data.date_valid),
                                    32'(want_date.date_valid));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d results pending", cycle_count,
                     end_date_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_field_extremes;
        send_date(date_req(0, 1, 2024, 5));
        send_date(date_req(31, 1, 2024, 0));
        send_date(date_req(31, 4, 2024, 3));
        send_date(date_req(15, 0, 2024, 1));
        send_date(date_req(15, 13, 2024, 1));
        send_date(date_req(31, 15, 16383, 65535));
        send_date(date_req(1, 1, 0, 0));
        send_date(date_req(30, 11, 9999, 10));
    endtask

    task automatic test_leap_rules;
        send_date(date_req(29, 2, 2000, 1));
        send_date(date_req(29, 2, 1900, 1));
        send_date(date_req(29, 2, 2023, 0));
        send_date(date_req(28, 2, 2024, 1));
        send_date(date_req(28, 2, 2023, 1));
        send_date(date_req(29, 2, 0, 366));
        send_date(date_req(28, 2, 2100, 1));
    endtask

    task automatic test_rollovers;
        send_date(date_req(31, 1, 2023, 1));
        send_date(date_req(31, 12, 1999, 1));
        send_date(date_req(31, 12, 16383, 1));
        send_date(date_req(15, 6, 16383, 65535));
        send_date(date_req(1, 1, 2000, 65535));
        send_date(date_req(30, 9, 2024, 0));
    endtask

    // hold the receiver off while requests keep coming, so the input stalls
    task automatic test_backpressure;
        hold_ticket <= hold_ticket + 1;
        for (int i = 0; i < 8; i++) begin
            send_date(date_req($urandom_range(28, 1), $urandom_range(12, 1),
                               $urandom_range(16383), $urandom_range(3)));
        end
    endtask

    task automatic test_random_traffic;
        t_date_in req;
        int       month;
        int       year;
        int       len;
        calm <= 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 30) calm <= 1'b0;
            if ($urandom_range(99) < 20) begin
                req.start_day   = 5'($urandom_range(31));
                req.start_month = 4'($urandom_range(15));
                req.start_year  = 14'($urandom_range(16383));
            end else begin
                month = $urandom_range(12, 1);
                case ($urandom_range(3))
                    0:       year = $urandom_range(16383);
                    1:       year = $urandom_range(2100, 1900);
                    2:       year = 100 * $urandom_range(163);
                    default: year = 400 * $urandom_range(40);
                endcase
                len = days_in_month(month[3:0], year[13:0]);
                req.start_month = month[3:0];
                req.start_year  = year[13:0];
                req.start_day   = ($urandom_range(9) == 0) ? len[4:0]
                                                           : 5'($urandom_range(len, 1));
            end
            if (i % 33 == 16)
                req.days_ahead = 16'($urandom_range(65535, 32768));
            else if ($urandom_range(99) < 15)
                req.days_ahead = 16'($urandom_range(3000));
            else
                req.days_ahead = 16'($urandom_range(400));
            send_date(req);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_field_extremes();
        test_leap_rules();
        test_rollovers();
        test_backpressure();
        test_random_traffic();
        i_in_valid <= 1'b0;
        while (end_date_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d of %0d dates: field extremes, leap rules, rollovers,",
                 dates_checked, dates_sent);
        $display("a long output hold-off and random valid and malformed dates.");
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
